@@ hdl/des_pkg.sv @@
// DES package: bit permutation helpers, S-box lookup and round constants.
// Used by the round cell and the top level; depends on nothing else.
`default_nettype none
package des_pkg;

  localparam int NumRounds = 16;

  // Control carried alongside each item through the round chain.
  typedef struct packed {
    logic valid;
    logic decrypt;
  } des_ctl_t;

  // Initial permutation.
  function automatic logic [63:0] ip_perm(input logic [63:0] x);
    logic [7:0] tab [64];
    logic [63:0] y;
    tab = '{8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,
            8'd12,8'd4,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,8'd64,8'd56,8'd48,8'd40,
            8'd32,8'd24,8'd16,8'd8,8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd59,8'd51,
            8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,
            8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};
    for (int i = 0; i < 64; i++) y[63-i] = x[64-tab[i]];
    return y;
  endfunction

  // Final (inverse) permutation.
  function automatic logic [63:0] fp_perm(input logic [63:0] x);
    logic [7:0] tab [64];
    logic [63:0] y;
    tab = '{8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32,8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,
            8'd63,8'd31,8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30,8'd37,8'd5,8'd45,8'd13,
            8'd53,8'd21,8'd61,8'd29,8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28,8'd35,8'd3,
            8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26,
            8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};
    for (int i = 0; i < 64; i++) y[63-i] = x[64-tab[i]];
    return y;
  endfunction

  // Key permutation PC-1 (standard table, parity bits dropped).
  function automatic logic [55:0] pc1_perm(input logic [63:0] x);
    logic [7:0] tab [56];
    logic [55:0] y;
    tab = '{8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
            8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
            8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
            8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};
    for (int i = 0; i < 56; i++) y[55-i] = x[64-tab[i]];
    return y;
  endfunction

  // Subkey selection PC-2.
  function automatic logic [47:0] pc2_perm(input logic [55:0] x);
    logic [7:0] tab [48];
    logic [47:0] y;
    tab = '{8'd14,8'd17,8'd11,8'd24,8'd1,8'd5,8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
            8'd23,8'd19,8'd12,8'd4,8'd26,8'd8,8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
            8'd41,8'd52,8'd31,8'd37,8'd47,8'd55,8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
            8'd44,8'd49,8'd39,8'd56,8'd34,8'd53,8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};
    for (int i = 0; i < 48; i++) y[47-i] = x[56-tab[i]];
    return y;
  endfunction

  // Expansion E.
  function automatic logic [47:0] e_perm(input logic [31:0] x);
    logic [7:0] tab [48];
    logic [47:0] y;
    tab = '{8'd32,8'd1,8'd2,8'd3,8'd4,8'd5,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
            8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
            8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
            8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};
    for (int i = 0; i < 48; i++) y[47-i] = x[32-tab[i]];
    return y;
  endfunction

  // Permutation P.
  function automatic logic [31:0] p_perm(input logic [31:0] x);
    logic [7:0] tab [32];
    logic [31:0] y;
    tab = '{8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17,8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,
            8'd31,8'd10,8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,8'd19,8'd13,8'd30,8'd6,
            8'd22,8'd11,8'd4,8'd25};
    for (int i = 0; i < 32; i++) y[31-i] = x[32-tab[i]];
    return y;
  endfunction

  // S-box lookup: box 0..7, index is row*16 + column.
  function automatic logic [3:0] sbox(input logic [2:0] box, input logic [5:0] idx);
    logic [3:0] t [8][64];
    t = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};
    return t[box][idx];
  endfunction

  // Round function f(R, K).
  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [5:0] six;
    x = e_perm(r) ^ k;
    for (int b = 0; b < 8; b++) begin
      six = x[47-6*b -: 6];
      s[31-4*b -: 4] = sbox(3'(b), {six[5], six[0], six[4:1]});
    end
    return p_perm(s);
  endfunction

endpackage
`default_nettype wire

@@ hdl/des_if.sv @@
// Valid/ready stream interfaces for the DES block.
// Depends on nothing.
`default_nettype none
interface des_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] data_block;
  logic [63:0] cipher_key;
  modport source (output valid, action, data_block, cipher_key, input ready);
  modport sink   (input valid, action, data_block, cipher_key, output ready);
endinterface

interface des_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_block;
  modport source (output valid, result_block, input ready);
  modport sink   (input valid, result_block, output ready);
endinterface
`default_nettype wire

@@ hdl/des_round.sv @@
// One DES round cell: Feistel round plus key-schedule rotation for its stage.
// Depends on des_pkg.
`default_nettype none
module des_round_cell #(
  parameter int Round = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire des_pkg::des_ctl_t ctl_in,
  input  wire logic [31:0]      l_in,
  input  wire logic [31:0]      r_in,
  input  wire logic [55:0]      cd_in,
  output des_pkg::des_ctl_t     ctl_out,
  output logic [31:0]           l_out,
  output logic [31:0]           r_out,
  output logic [55:0]           cd_out
);
  // Single-rotation rounds: first, second, ninth and last.
  localparam bit One = (Round == 0) || (Round == 1) || (Round == 8) || (Round == 15);
  // Decrypt walks the schedule backwards; rotate right before use, except round 0.
  localparam int RShift = (Round == 0) ? 0 :
                          ((Round == 1) || (Round == 8) || (Round == 15)) ? 1 : 2;

  logic [27:0] c, d, ce, de, cd_, dd;
  logic [55:0] cd_use, cd_nxt;
  logic [31:0] l_nxt, r_nxt;

  always_comb begin
    c = cd_in[55:28];
    d = cd_in[27:0];
    // Encrypt: left rotate then use.
    ce = One ? {c[26:0], c[27]} : {c[25:0], c[27:26]};
    de = One ? {d[26:0], d[27]} : {d[25:0], d[27:26]};
    // Decrypt: use after right rotate (stage 0 uses the PC-1 value directly).
    case (RShift)
      1: begin
        cd_ = {c[0], c[27:1]};
        dd  = {d[0], d[27:1]};
      end
      2: begin
        cd_ = {c[1:0], c[27:2]};
        dd  = {d[1:0], d[27:2]};
      end
      default: begin
        cd_ = c;
        dd  = d;
      end
    endcase
    cd_use = ctl_in.decrypt ? {cd_, dd} : {ce, de};
    cd_nxt = cd_use;
    l_nxt  = r_in;
    r_nxt  = l_in ^ des_pkg::feistel(r_in, des_pkg::pc2_perm(cd_use));
  end

  // Stage register: control resets, payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_out  <= l_nxt;
      r_out  <= r_nxt;
      cd_out <= cd_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hdl/des_block_cipher.sv @@
// Top level of the DES block: input permutation, chain of round cells, output stage.
// Depends on des_pkg, des_if and des_round_cell.
`default_nettype none
// Fully pipelined DES: one 64-bit block with its own key and direction enters every
// cycle while the chain advances, and its result leaves from the last round cell. The chain
// advances whenever the output register is empty or being taken, so a stalled
// consumer holds the whole chain; throughput is one block per cycle when not stalled.
module des_block_cipher (
  input wire logic    clk,
  input wire logic    rst_n,
  des_in_if.sink      in_ch,
  des_out_if.source   out_ch
);
  localparam int N = des_pkg::NumRounds;

  des_pkg::des_ctl_t ctl [N+1];
  logic [31:0] lh [N+1];
  logic [31:0] rh [N+1];
  logic [55:0] cdv [N+1];
  logic [63:0] pre;
  logic        en;

  // The chain moves when the last stage is empty or its result is taken.
  assign en          = !ctl[N].valid || out_ch.ready;
  assign in_ch.ready = en;

  assign pre          = des_pkg::ip_perm(in_ch.data_block);
  assign ctl[0].valid = in_ch.valid;
  assign ctl[0].decrypt = in_ch.action;
  assign lh[0]  = pre[63:32];
  assign rh[0]  = pre[31:0];
  assign cdv[0] = des_pkg::pc1_perm(in_ch.cipher_key);

  for (genvar g = 0; g < N; g++) begin : g_round
    des_round_cell #(.Round(g)) u_round (
      .clk, .rst_n, .en,
      .ctl_in(ctl[g]), .l_in(lh[g]), .r_in(rh[g]), .cd_in(cdv[g]),
      .ctl_out(ctl[g+1]), .l_out(lh[g+1]), .r_out(rh[g+1]), .cd_out(cdv[g+1])
    );
  end

  // Final swap and inverse permutation on the last cell's register.
  assign out_ch.valid        = ctl[N].valid;
  assign out_ch.result_block = des_pkg::fp_perm({rh[N], lh[N]});

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_block))
    else $error("result changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> ctl[1].valid)
    else $error("accepted block lost in first cell");
endmodule
`default_nettype wire
